FILE: src/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// shared types and codes of the timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ID_PORT_W = 16;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned IN_W     = 56;
    localparam int unsigned OUT_W    = 56;

    typedef enum logic [2:0] {
        ACT_ADD             = 3'd0,
        ACT_ADD_UNLESS_PAST = 3'd1,
        ACT_REMOVE          = 3'd2,
        ACT_ADVANCE         = 3'd3,
        ACT_QUERY           = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_FIRED     = 3'd0,
        ST_ADDED     = 3'd1,
        ST_DROP_FULL = 3'd2,
        ST_DROP_PAST = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_MATCH     = 3'd5,
        ST_NONE      = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_ADVANCE,
        S_FIRE,
        S_QUERY,
        S_SCAN,
        S_NONE
    } t_state;

    typedef struct packed {
        logic head_le;
        logic head_eq;
        logic next_le;
        logic next_eq;
        logic any_eq;
    } t_chain_stat;

endpackage

FILE: src/timed_event_queue_unit.sv
// ----------------------------------------------------------------------------
// timed_event_queue_unit
// sorted timer event queue with add, remove, advance and query requests
// ----------------------------------------------------------------------------
// slave channel: one request per beat (action, time value, event id); the
// port is ready only between requests, so one request is worked at a time.
// master channel: one or more results per request, tlast on the final one.
//   add, add unless past, unknown action: one result
//   remove:  matches removed one per cycle, then one result
//   advance: one result if nothing fires, else one per fired event,
//            one per cycle while the receiver is ready
//   query:   one result without a match, else one full rotation of
//            the cell row; matches leave as they pass the head
// the next request can be taken in the cycle after the last result is
// loaded into the output register, except after a query with matches,
// which ends with its rotation. while the receiver stalls the sequencer
// waits and nothing is lost. a synchronous reset empties the row and
// clears the current time, no clearing pass needed.
// ----------------------------------------------------------------------------
module timed_event_queue_unit #(
    parameter int unsigned DEPTH   = 16,
    parameter int unsigned ID_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // action[2:0], time_value[34:3], event_id[50:35], zero pad
    input  logic [teq_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // status[2:0], event_id_res[18:3], event_time[50:19], count[55:51]
    output logic [teq_pkg::OUT_W-1:0]  o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);
    import teq_pkg::*;

    localparam int unsigned ID_W   = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
    localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
    localparam int unsigned STEP_W = $clog2(DEPTH);

    t_state            r_state, n_state;
    t_action           r_act;
    logic [31:0]       r_time;
    logic [ID_W-1:0]   r_id;
    logic [31:0]       r_cur, n_cur;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [OCC_W-1:0]  r_cnt, n_cnt;
    logic [STEP_W-1:0] r_step, n_step;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [ID_PORT_W-1:0] r_out_id;
    logic [31:0]       r_out_time;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic              w_emit;
    t_status           w_emit_status;
    logic [ID_PORT_W-1:0] w_emit_id;
    logic [31:0]       w_emit_time;
    logic [CNT_W-1:0]  w_emit_cnt;
    logic              w_emit_last;
    t_cell_op          w_op;
    logic [31:0]       w_key;
    logic [32:0]       w_sum;
    logic              w_past;
    logic              w_step_end;

    t_chain_stat       w_stat;
    logic [31:0]       w_head_due;
    logic [ID_W-1:0]   w_head_id;
    logic [DEPTH-1:0]  w_valid;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_sum      = {1'b0, r_cur} + {1'b0, r_time};
    assign w_past     = (r_act == ACT_ADD_UNLESS_PAST) && (r_time < r_cur);
    assign w_step_end = (r_step == STEP_W'(DEPTH - 1));
    assign w_key      = (r_state == S_FIRE) ? r_cur : r_time;

    teq_chain #(
        .DEPTH (DEPTH),
        .ID_W  (ID_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_key      (w_key),
        .i_new_due  (r_time),
        .i_new_id   (r_id),
        .o_stat     (w_stat),
        .o_head_due (w_head_due),
        .o_head_id  (w_head_id),
        .o_valid    (w_valid)
    );

    always_comb begin
        n_state         = r_state;
        n_cur           = r_cur;
        n_occ           = r_occ;
        n_cnt           = r_cnt;
        n_step          = r_step;
        o_s_axis_tready = 1'b0;
        w_op            = CELL_HOLD;
        w_emit          = 1'b0;
        w_emit_status   = ST_NONE;
        w_emit_id       = '0;
        w_emit_time     = '0;
        w_emit_cnt      = '0;
        w_emit_last     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                n_cnt           = '0;
                n_step          = '0;
                if (i_s_axis_tvalid) begin
                    unique case (t_action'(i_s_axis_tdata[2:0])) inside
                        ACT_ADD, ACT_ADD_UNLESS_PAST: n_state = S_ADD;
                        ACT_REMOVE:                   n_state = S_REMOVE;
                        ACT_ADVANCE:                  n_state = S_ADVANCE;
                        ACT_QUERY:                    n_state = S_QUERY;
                        default:                      n_state = S_NONE;
                    endcase
                end
            end
            S_ADD: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_id   = ID_PORT_W'(r_id);
                    w_emit_time = r_time;
                    n_state     = S_IDLE;
                    if (w_past) begin
                        w_emit_status = ST_DROP_PAST;
                        w_emit_cnt    = CNT_W'(r_occ);
                    end else if (r_occ == OCC_W'(DEPTH)) begin
                        w_emit_status = ST_DROP_FULL;
                        w_emit_cnt    = CNT_W'(r_occ);
                    end else begin
                        w_op          = CELL_INSERT;
                        n_occ         = r_occ + OCC_W'(1);
                        w_emit_status = ST_ADDED;
                        w_emit_cnt    = CNT_W'(n_occ);
                    end
                end
            end
            S_REMOVE: begin
                if (w_stat.any_eq) begin
                    w_op  = CELL_REMOVE;
                    n_occ = r_occ - OCC_W'(1);
                    n_cnt = r_cnt + OCC_W'(1);
                end else if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = ST_REMOVED;
                    w_emit_time   = r_time;
                    w_emit_cnt    = CNT_W'(r_cnt);
                    n_state       = S_IDLE;
                end
            end
            S_ADVANCE: begin
                n_cur   = w_sum[32] ? '1 : w_sum[31:0];
                n_state = S_FIRE;
            end
            S_FIRE: begin
                if (w_stat.head_le) begin
                    if (w_out_free) begin
                        w_op          = CELL_SHIFT;
                        n_occ         = r_occ - OCC_W'(1);
                        w_emit        = 1'b1;
                        w_emit_status = ST_FIRED;
                        w_emit_id     = ID_PORT_W'(w_head_id);
                        w_emit_time   = w_head_due;
                        w_emit_last   = !w_stat.next_le;
                        if (!w_stat.next_le) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = ST_NONE;
                    w_emit_time   = r_cur;
                    n_state       = S_IDLE;
                end
            end
            S_QUERY: begin
                if (w_stat.any_eq) begin
                    n_state = S_SCAN;
                end else if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = ST_NONE;
                    w_emit_time   = r_time;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_out_free || !w_stat.head_eq) begin
                    w_op   = CELL_ROTATE;
                    n_step = r_step + STEP_W'(1);
                    if (w_stat.head_eq) begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_MATCH;
                        w_emit_id     = ID_PORT_W'(w_head_id);
                        w_emit_time   = w_head_due;
                        w_emit_last   = !w_stat.next_eq || w_step_end;
                    end
                    if (w_step_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NONE: begin
                if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = ST_NONE;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= t_action'(i_s_axis_tdata[2:0]);
            r_time <= i_s_axis_tdata[34:3];
            r_id   <= ID_W'(i_s_axis_tdata[50:35]);
        end
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_id     <= w_emit_id;
            r_out_time   <= w_emit_time;
            r_out_cnt    <= w_emit_cnt;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_cnt, r_out_time, r_out_id, r_out_status};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_occ_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_occ))
        else $error("occupied cells disagree with occupancy");

    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cur >= $past(r_cur))
        else $error("current time went backwards");

    a_fire_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FIRED) |-> r_out_time <= r_cur)
        else $error("fired event not yet due");
`endif

endmodule

FILE: src/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// one slot of the sorted event row: holds a due time and an identifier
// ----------------------------------------------------------------------------
module teq_cell #(
    parameter int unsigned ID_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  teq_pkg::t_cell_op     i_op,
    input  logic [31:0]           i_key,
    input  logic [31:0]           i_new_due,
    input  logic [ID_W-1:0]       i_new_id,
    input  logic                  i_any_eq,
    input  logic                  i_left_le,
    input  logic                  i_left_valid,
    input  logic [31:0]           i_left_due,
    input  logic [ID_W-1:0]       i_left_id,
    input  logic                  i_right_valid,
    input  logic [31:0]           i_right_due,
    input  logic [ID_W-1:0]       i_right_id,
    output logic                  o_valid,
    output logic [31:0]           o_due,
    output logic [ID_W-1:0]       o_id,
    output logic                  o_le,
    output logic                  o_eq
);
    import teq_pkg::*;

    logic            r_valid;
    logic [31:0]     r_due;
    logic [ID_W-1:0] r_id;
    logic            n_valid;
    logic [31:0]     n_due;
    logic [ID_W-1:0] n_id;
    logic            w_lt;
    logic            w_eq;

    assign w_lt = r_valid && (r_due < i_key);
    assign w_eq = r_valid && (r_due == i_key);

    always_comb begin
        n_valid = r_valid;
        n_due   = r_due;
        n_id    = r_id;
        unique case (i_op)
            CELL_INSERT: begin
                if (!i_left_le) begin
                    n_valid = i_left_valid;
                    n_due   = i_left_due;
                    n_id    = i_left_id;
                end else if (!(w_lt || w_eq)) begin
                    n_valid = 1'b1;
                    n_due   = i_new_due;
                    n_id    = i_new_id;
                end
            end
            CELL_REMOVE: begin
                if (i_any_eq && !w_lt) begin
                    n_valid = i_right_valid;
                    n_due   = i_right_due;
                    n_id    = i_right_id;
                end
            end
            CELL_SHIFT, CELL_ROTATE: begin
                n_valid = i_right_valid;
                n_due   = i_right_due;
                n_id    = i_right_id;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_due <= n_due;
        r_id  <= n_id;
    end

    assign o_valid = r_valid;
    assign o_due   = r_due;
    assign o_id    = r_id;
    assign o_le    = w_lt || w_eq;
    assign o_eq    = w_eq;

endmodule

FILE: src/teq_chain.sv
// ----------------------------------------------------------------------------
// teq_chain
// row of event cells kept sorted by due time, oldest arrival first on ties
// ----------------------------------------------------------------------------
module teq_chain #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ID_W  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  teq_pkg::t_cell_op     i_op,
    input  logic [31:0]           i_key,
    input  logic [31:0]           i_new_due,
    input  logic [ID_W-1:0]       i_new_id,
    output teq_pkg::t_chain_stat  o_stat,
    output logic [31:0]           o_head_due,
    output logic [ID_W-1:0]       o_head_id,
    output logic [DEPTH-1:0]      o_valid
);
    import teq_pkg::*;

    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_le;
    logic [DEPTH-1:0] w_eq;
    logic [31:0]      w_due [DEPTH];
    logic [ID_W-1:0]  w_id  [DEPTH];
    logic             w_any_eq;

    assign w_any_eq = |w_eq;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic            w_left_le;
        logic            w_left_valid;
        logic [31:0]     w_left_due;
        logic [ID_W-1:0] w_left_id;
        logic            w_right_valid;
        logic [31:0]     w_right_due;
        logic [ID_W-1:0] w_right_id;

        if (g == 0) begin : g_first
            assign w_left_le    = 1'b1;
            assign w_left_valid = 1'b0;
            assign w_left_due   = '0;
            assign w_left_id    = '0;
        end else begin : g_mid
            assign w_left_le    = w_le[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_due   = w_due[g-1];
            assign w_left_id    = w_id[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            // wraps to the head while rotating, empty otherwise
            assign w_right_valid = (i_op == CELL_ROTATE) ? w_valid[0] : 1'b0;
            assign w_right_due   = w_due[0];
            assign w_right_id    = w_id[0];
        end else begin : g_inner
            assign w_right_valid = w_valid[g+1];
            assign w_right_due   = w_due[g+1];
            assign w_right_id    = w_id[g+1];
        end

        teq_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (i_op),
            .i_key         (i_key),
            .i_new_due     (i_new_due),
            .i_new_id      (i_new_id),
            .i_any_eq      (w_any_eq),
            .i_left_le     (w_left_le),
            .i_left_valid  (w_left_valid),
            .i_left_due    (w_left_due),
            .i_left_id     (w_left_id),
            .i_right_valid (w_right_valid),
            .i_right_due   (w_right_due),
            .i_right_id    (w_right_id),
            .o_valid       (w_valid[g]),
            .o_due         (w_due[g]),
            .o_id          (w_id[g]),
            .o_le          (w_le[g]),
            .o_eq          (w_eq[g])
        );
    end

    assign o_stat.head_le = w_le[0];
    assign o_stat.head_eq = w_eq[0];
    assign o_stat.next_le = w_le[1];
    assign o_stat.next_eq = w_eq[1];
    assign o_stat.any_eq  = w_any_eq;
    assign o_head_due     = w_due[0];
    assign o_head_id      = w_id[0];
    assign o_valid        = w_valid;

endmodule
